FILE: hw/rtl/prp_pkg.sv
// Shared types, register indexes and constants of the point rotate and
// perspective core. No dependencies; every other file imports it.
package prp_pkg;

  localparam int COORD_W = 24;
  localparam int COEF_W  = 17;

  localparam logic [2:0] CFG_PITCH    = 3'd0;
  localparam logic [2:0] CFG_YAW      = 3'd1;
  localparam logic [2:0] CFG_DEPTH    = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_X = 3'd3;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd4;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd5;

  localparam logic signed [16:0] HALF_TURN    = 17'sd23040;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;
  localparam logic signed [32:0] CORDIC_X0    = 33'sd652032874;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] proj_x;
    logic signed [COORD_W-1:0] proj_y;
    logic                      back_facing;
    logic                      overflow;
  } out_t;

  // Rotation matrix terms in Q1.15, plus the facing flag.
  typedef struct packed {
    logic signed [COEF_W-1:0] sp;
    logic signed [COEF_W-1:0] cp;
    logic signed [COEF_W-1:0] sy;
    logic signed [COEF_W-1:0] cy;
    logic signed [COEF_W-1:0] m_sp_sy;
    logic signed [COEF_W-1:0] m_nsp_cy;
    logic signed [COEF_W-1:0] m_ncp_sy;
    logic signed [COEF_W-1:0] m_cp_cy;
    logic                     back;
  } coef_t;

  // Arctangent of 2^-i in 1/32768 degree.
  function automatic logic [20:0] atan_step(input logic [3:0] i);
    logic [20:0] r;
    begin
      case (i)
        4'd0:  r = 21'd1474560;
        4'd1:  r = 21'd870484;
        4'd2:  r = 21'd459940;
        4'd3:  r = 21'd233473;
        4'd4:  r = 21'd117189;
        4'd5:  r = 21'd58652;
        4'd6:  r = 21'd29333;
        4'd7:  r = 21'd14667;
        4'd8:  r = 21'd7334;
        4'd9:  r = 21'd3667;
        4'd10: r = 21'd1833;
        4'd11: r = 21'd917;
        4'd12: r = 21'd458;
        4'd13: r = 21'd229;
        4'd14: r = 21'd115;
        default: r = 21'd57;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: hw/rtl/prp_setup.sv
// Configuration registers and the setup sequencer: strength divider,
// shared CORDIC for sine and cosine, and the matrix product terms.
// Depends on prp_pkg.
module prp_setup #(
  parameter int FRAC_BITS = 8,
  localparam int NDW = 14 + 2 * FRAC_BITS,
  localparam int SW = NDW + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [23:0]                   cfg_data,
  output logic                          busy,
  output prp_pkg::coef_t                coef,
  output logic signed [SW-1:0]          strength,
  output logic signed [prp_pkg::COORD_W-1:0] origin_x,
  output logic signed [prp_pkg::COORD_W-1:0] origin_y,
  output logic signed [prp_pkg::COORD_W-1:0] origin_z
);
  import prp_pkg::*;

  localparam int CW = $clog2(NDW);
  localparam logic [NDW-1:0] NUM = NDW'(10000) << (2 * FRAC_BITS);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CORD = 3'd2;
  localparam logic [2:0] ST_MAT  = 3'd3;
  localparam logic [2:0] ST_IDLE = 3'd4;

  logic [2:0]               state;
  logic [CW-1:0]            cnt;
  logic                     pass;
  logic signed [15:0]       pitch, yaw;
  logic signed [23:0]       depth;
  logic [23:0]              dabs;
  logic                     dneg;
  logic [23:0]              rem;
  logic [NDW-1:0]           quo;
  logic signed [32:0]       cx, cy_r;
  logic signed [24:0]       cz;
  logic                     neg_p, neg_y;

  logic [24:0]              trial;
  logic                     take;
  logic [NDW-1:0]           quo_next;
  logic signed [16:0]       wp, wy, fp, fy;
  logic                     fnp, fny;
  logic signed [32:0]       dx, dy, cx_next, cy_next;
  logic signed [24:0]       cz_next;
  logic signed [17:0]       sn_full, cs_full;
  logic signed [16:0]       sn, cs;
  logic signed [16:0]       ma, mb;
  logic                     mneg;
  logic signed [35:0]       mprod, mval;
  logic signed [16:0]       mres;

  function automatic logic signed [16:0] wrap17(input logic signed [15:0] a);
    logic signed [16:0] w;
    begin
      w = 17'(a);
      if (w > HALF_TURN) w = w - (HALF_TURN <<< 1);
      if (w < -HALF_TURN) w = w + (HALF_TURN <<< 1);
      return w;
    end
  endfunction

  always_comb begin
    wp = wrap17(pitch);
    wy = wrap17(yaw);
    fp = wp;
    fnp = 1'b0;
    if (wp > QUARTER_TURN) begin
      fp = HALF_TURN - wp;
      fnp = 1'b1;
    end
    if (wp < -QUARTER_TURN) begin
      fp = -HALF_TURN - wp;
      fnp = 1'b1;
    end
    fy = wy;
    fny = 1'b0;
    if (wy > QUARTER_TURN) begin
      fy = HALF_TURN - wy;
      fny = 1'b1;
    end
    if (wy < -QUARTER_TURN) begin
      fy = -HALF_TURN - wy;
      fny = 1'b1;
    end
  end

  // One restoring step of the strength division per cycle.
  always_comb begin
    trial = {rem, NUM[cnt]};
    take = trial >= {1'b0, dabs};
    quo_next = {quo[NDW-2:0], take};
  end

  // One CORDIC rotation per cycle.
  always_comb begin
    dx = cy_r >>> cnt[3:0];
    dy = cx >>> cnt[3:0];
    if (cz >= 0) begin
      cx_next = cx - dx;
      cy_next = cy_r + dy;
      cz_next = cz - 25'(atan_step(cnt[3:0]));
    end else begin
      cx_next = cx + dx;
      cy_next = cy_r - dy;
      cz_next = cz + 25'(atan_step(cnt[3:0]));
    end
    sn_full = 18'((cy_next + 33'sd16384) >>> 15);
    cs_full = 18'((cx_next + 33'sd16384) >>> 15);
    sn = sn_full[16:0];
    cs = cs_full[16:0];
  end

  // Matrix product terms, one per cycle through a shared multiplier.
  always_comb begin
    case (cnt[1:0])
      2'd0:    begin ma = coef.sp; mb = coef.sy; mneg = 1'b0; end
      2'd1:    begin ma = coef.sp; mb = coef.cy; mneg = 1'b1; end
      2'd2:    begin ma = coef.cp; mb = coef.sy; mneg = 1'b1; end
      default: begin ma = coef.cp; mb = coef.cy; mneg = 1'b0; end
    endcase
    mprod = 36'(ma * mb);
    mval = mneg ? -mprod : mprod;
    mres = 17'((mval + 36'sd16384) >>> 15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      cnt      <= '0;
      pass     <= 1'b0;
      pitch    <= '0;
      yaw      <= '0;
      depth    <= 24'sd2560;
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          dneg  <= depth[23];
          dabs  <= (depth == 0) ? 24'd1 : (depth[23] ? 24'(-depth) : 24'(depth));
          rem   <= '0;
          quo   <= '0;
          cnt   <= CW'(NDW - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= take ? 24'(trial - {1'b0, dabs}) : trial[23:0];
          quo <= quo_next;
          if (cnt == 0) begin
            strength <= dneg ? -SW'(quo_next) : SW'(quo_next);
            cx       <= CORDIC_X0;
            cy_r     <= '0;
            cz       <= 25'(fp) <<< 8;
            pass     <= 1'b0;
            state    <= ST_CORD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_CORD: begin
          cx   <= cx_next;
          cy_r <= cy_next;
          cz   <= cz_next;
          if (cnt[3:0] == 4'd15) begin
            cnt <= '0;
            if (!pass) begin
              coef.sp <= sn;
              coef.cp <= fnp ? -cs : cs;
              neg_p   <= fnp;
              cx      <= CORDIC_X0;
              cy_r    <= '0;
              cz      <= 25'(fy) <<< 8;
              pass    <= 1'b1;
            end else begin
              coef.sy <= sn;
              coef.cy <= fny ? -cs : cs;
              neg_y   <= fny;
              state   <= ST_MAT;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_MAT: begin
          case (cnt[1:0])
            2'd0:    coef.m_sp_sy  <= mres;
            2'd1:    coef.m_nsp_cy <= mres;
            2'd2:    coef.m_ncp_sy <= mres;
            default: coef.m_cp_cy  <= mres;
          endcase
          coef.back <= neg_p ^ neg_y;
          if (cnt[1:0] == 2'd3) state <= ST_IDLE;
          else cnt <= cnt + 1'b1;
        end
        ST_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              CFG_PITCH:    begin pitch    <= cfg_data[15:0]; state <= ST_LOAD; end
              CFG_YAW:      begin yaw      <= cfg_data[15:0]; state <= ST_LOAD; end
              CFG_DEPTH:    begin depth    <= cfg_data;       state <= ST_LOAD; end
              CFG_ORIGIN_X: begin origin_x <= cfg_data;       state <= ST_LOAD; end
              CFG_ORIGIN_Y: begin origin_y <= cfg_data;       state <= ST_LOAD; end
              CFG_ORIGIN_Z: begin origin_z <= cfg_data;       state <= ST_LOAD; end
              default: ;
            endcase
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);
  assign cfg_ready = !busy;

endmodule

FILE: hw/rtl/point_rotate_perspective_core.sv
// Top level of the point rotate and perspective core: streaming point
// pipeline with a pipelined divider. Depends on prp_pkg and prp_setup.
//
// Takes one point request per clock and returns one projected point per
// clock while the output does not stall and setup is idle; the pipeline
// runs 5 arithmetic stages, then one stage per quotient bit of the
// 28-bit perspective divider, then the output register. The whole
// pipeline holds when the output request waits unanswered. After reset
// and after every write to a known register, the setup sequencer
// recomputes the perspective strength (14 + 2*FRAC_BITS division steps),
// pitch and yaw sine and cosine (two 16-step CORDIC passes) and four
// matrix terms, during which neither point nor configuration requests
// are taken. Write configuration only with the pipeline empty.
module point_rotate_perspective_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  prp_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output prp_pkg::out_t   out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [23:0]     cfg_data
);
  import prp_pkg::*;

  localparam int NDW  = 14 + 2 * FRAC_BITS;
  localparam int SW   = NDW + 1;
  localparam int RW   = 28;                         // rotated coordinate
  localparam int DW   = ((SW > RW) ? SW : RW) + 1;  // divisor
  localparam int NW   = 2 * RW;                     // dividend magnitude
  localparam int CMPW = ((NW > DW) ? NW : DW);
  localparam int QB   = 28;                         // quotient bits kept

  logic                     busy;
  coef_t                    coef;
  logic signed [SW-1:0]     strength;
  logic signed [COORD_W-1:0] ox, oy, oz;
  logic                     en;

  prp_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .coef      (coef),
    .strength  (strength),
    .origin_x  (ox),
    .origin_y  (oy),
    .origin_z  (oz)
  );

  // Advance every stage unless the output holds an unanswered result.
  assign en = !out_valid || out_ready;
  assign in_ready = en && !busy;

  // Stage 1: move the point into origin-relative coordinates.
  logic                    v1;
  logic signed [24:0]      px1, py1, pz1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= 25'(in_data.point_x) - 25'(ox);
      py1 <= 25'(in_data.point_y) - 25'(oy);
      pz1 <= 25'(in_data.point_z) - 25'(oz);
    end
  end

  // Stage 2: the eight matrix products.
  logic                    v2;
  logic signed [41:0]      ax, bx, cxp, by, cyp, az, bz, cz;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax  <= 42'(coef.cy * px1);
      bx  <= 42'(coef.m_sp_sy * py1);
      cxp <= 42'(coef.m_ncp_sy * pz1);
      by  <= 42'(coef.cp * py1);
      cyp <= 42'(coef.sp * pz1);
      az  <= 42'(coef.sy * px1);
      bz  <= 42'(coef.m_nsp_cy * py1);
      cz  <= 42'(coef.m_cp_cy * pz1);
    end
  end

  // Stage 3: sum and round the rotated coordinates.
  logic                    v3;
  logic signed [RW-1:0]    rx3, ry3, rz3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx3 <= RW'((44'(ax) + 44'(bx) + 44'(cxp) + 44'sd16384) >>> 15);
      ry3 <= RW'((44'(by) + 44'(cyp) + 44'sd16384) >>> 15);
      rz3 <= RW'((44'(az) + 44'(bz) + 44'(cz) + 44'sd16384) >>> 15);
    end
  end

  // Stage 4: dividends r*rz and the divisor strength + rz.
  logic                    v4;
  logic signed [RW-1:0]    rx4, ry4;
  logic signed [NW-1:0]    numx4, numy4;
  logic signed [DW-1:0]    den4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx4   <= rx3;
      ry4   <= ry3;
      numx4 <= NW'(rx3 * rz3);
      numy4 <= NW'(ry3 * rz3);
      den4  <= DW'(strength) + DW'(rz3);
    end
  end

  // Stage 5 feeds divider slot 0: magnitudes, quotient signs, and a flag
  // for quotients too large to matter (they saturate the result anyway).
  logic [NW-1:0]           magx, magy;
  logic [DW-1:0]           magd;

  always_comb begin
    magx = numx4[NW-1] ? NW'(-numx4) : NW'(numx4);
    magy = numy4[NW-1] ? NW'(-numy4) : NW'(numy4);
    magd = den4[DW-1] ? DW'(-den4) : DW'(den4);
  end

  logic                    vd    [0:QB];
  logic [NW-1:0]           remx  [0:QB];
  logic [NW-1:0]           remy  [0:QB];
  logic [QB-1:0]           qx    [0:QB];
  logic [QB-1:0]           qy    [0:QB];
  logic [DW-1:0]           dmag  [0:QB];
  logic signed [RW-1:0]    rxd   [0:QB];
  logic signed [RW-1:0]    ryd   [0:QB];
  logic                    negx  [0:QB];
  logic                    negy  [0:QB];
  logic                    bigx  [0:QB];
  logic                    bigy  [0:QB];
  logic                    dzero [0:QB];

  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else if (en) vd[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      remx[0]  <= magx;
      remy[0]  <= magy;
      qx[0]    <= '0;
      qy[0]    <= '0;
      dmag[0]  <= magd;
      rxd[0]   <= rx4;
      ryd[0]   <= ry4;
      negx[0]  <= numx4[NW-1] ^ den4[DW-1];
      negy[0]  <= numy4[NW-1] ^ den4[DW-1];
      bigx[0]  <= CMPW'(magx >> QB) >= CMPW'(magd);
      bigy[0]  <= CMPW'(magy >> QB) >= CMPW'(magd);
      dzero[0] <= (den4 == '0);
    end
  end

  // Divider: one restoring quotient bit per stage, MSB first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic          tx, ty;

    assign tx = CMPW'(remx[j] >> K) >= CMPW'(dmag[j]);
    assign ty = CMPW'(remy[j] >> K) >= CMPW'(dmag[j]);

    always_ff @(posedge clk) begin
      if (rst) vd[j+1] <= 1'b0;
      else if (en) vd[j+1] <= vd[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx[j+1]  <= tx ? remx[j] - (NW'(dmag[j]) << K) : remx[j];
        remy[j+1]  <= ty ? remy[j] - (NW'(dmag[j]) << K) : remy[j];
        qx[j+1]    <= {qx[j][QB-2:0], tx};
        qy[j+1]    <= {qy[j][QB-2:0], ty};
        dmag[j+1]  <= dmag[j];
        rxd[j+1]   <= rxd[j];
        ryd[j+1]   <= ryd[j];
        negx[j+1]  <= negx[j];
        negy[j+1]  <= negy[j];
        bigx[j+1]  <= bigx[j];
        bigy[j+1]  <= bigy[j];
        dzero[j+1] <= dzero[j];
      end
    end
  end

  // Output stage: apply quotient sign, add origin back, saturate.
  logic signed [QB+1:0]    sqx, sqy;
  logic signed [31:0]      resx, resy;
  logic                    satx, saty;
  out_t                    res;

  always_comb begin
    sqx = bigx[QB] ? (QB+2)'(1) <<< QB : (QB+2)'({1'b0, qx[QB]});
    sqy = bigy[QB] ? (QB+2)'(1) <<< QB : (QB+2)'({1'b0, qy[QB]});
    if (negx[QB]) sqx = -sqx;
    if (negy[QB]) sqy = -sqy;
    resx = 32'(rxd[QB]) - 32'(sqx) + 32'(ox);
    resy = 32'(ryd[QB]) - 32'(sqy) + 32'(oy);
    satx = (resx > 32'sd8388607) || (resx < -32'sd8388608);
    saty = (resy > 32'sd8388607) || (resy < -32'sd8388608);
    res.back_facing = coef.back;
    if (dzero[QB]) begin
      res.proj_x   = '0;
      res.proj_y   = '0;
      res.overflow = 1'b1;
    end else begin
      res.proj_x   = satx ? (resx[31] ? -24'sd8388608 : 24'sd8388607) : resx[23:0];
      res.proj_y   = saty ? (resy[31] ? -24'sd8388608 : 24'sd8388607) : resy[23:0];
      res.overflow = satx || saty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vd[QB];
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= res;
  end

endmodule

FILE: hw/rtl/prp_checker.sv
// Port-level checks for point_rotate_perspective_core, attached by bind.
// Depends on prp_pkg.
module prp_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input prp_pkg::out_t out_data,
  input logic          cfg_valid,
  input logic          cfg_ready,
  input logic [2:0]    cfg_index
);
  import prp_pkg::*;

  // A result that waits holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  // Points are never taken while setup runs.
  a_ready_setup: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> cfg_ready)
    else $error("point taken during setup");

  // A register write starts a setup pass.
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == CFG_PITCH || cfg_index == CFG_YAW ||
      cfg_index == CFG_DEPTH || cfg_index == CFG_ORIGIN_X ||
      cfg_index == CFG_ORIGIN_Y || cfg_index == CFG_ORIGIN_Z)
    |=> !in_ready && !cfg_ready)
    else $error("no setup pass after register write");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !in_ready)
    else $error("result or ready right after reset");

endmodule

bind point_rotate_perspective_core prp_checker u_prp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);

FILE: dv/testbench.sv
// Self-checking testbench for point_rotate_perspective_core: random and directed
// point requests, configuration phases, and a built-in model of the projection.
// Depends on prp_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import prp_pkg::*;

  localparam int FRAC = 8;
  localparam int PIPE_LAT = 40;

  typedef struct {
    logic [2:0]  idx;
    logic [23:0] val;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  point_rotate_perspective_core #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the registers, updated as writes are accepted.
  logic [15:0] sh_pitch = '0, sh_yaw = '0;
  logic [23:0] sh_depth = 24'd2560, sh_ox = '0, sh_oy = '0, sh_oz = '0;

  in_t        point_q[$];
  reg_write_t write_q[$];
  out_t       proj_q[$];
  int         errors = 0;
  bit         calm = 1'b0;

  // Bring an angle in 1/128 degree into -180..180.
  function automatic longint wrap_deg(logic [15:0] raw);
    longint a;
    a = longint'($signed(raw));
    if (a > 23040) a -= 46080;
    if (a < -23040) a += 46080;
    return a;
  endfunction

  function automatic longint rnd15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  // 16-step CORDIC, folded to +-90 degrees, results in Q1.15.
  function automatic void cordic(longint a, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    bit     neg;
    longint atans[16];
    atans = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
              7334, 3667, 1833, 917, 458, 229, 115, 57};
    neg = 1'b0;
    x = 652032874;
    y = 0;
    if (a > 11520) begin a = 23040 - a; neg = 1'b1; end
    if (a < -11520) begin a = -23040 - a; neg = 1'b1; end
    z = a * 256;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atans[i];
      end else begin
        x += dx; y -= dy; z += atans[i];
      end
    end
    sn = (y + 16384) >>> 15;
    cs = (x + 16384) >>> 15;
    if (neg) cs = -cs;
  endfunction

  function automatic longint clamp24(longint v, ref bit ovf);
    if (v > 8388607) begin ovf = 1'b1; return 8388607; end
    if (v < -8388608) begin ovf = 1'b1; return -8388608; end
    return v;
  endfunction

  // Project one point with the current register set.
  function automatic out_t project_point(in_t p);
    longint pa, ya, sp, cp, sy, cy, a_spsy, a_nspcy, a_ncpsy, a_cpcy;
    longint ox, oy, oz, px, py, pz, rx, ry, rz, d, s, den, fx, fy;
    bit     ovf;
    out_t   r;
    ovf = 1'b0;
    fx = 0;
    fy = 0;
    pa = wrap_deg(sh_pitch);
    ya = wrap_deg(sh_yaw);
    cordic(pa, sp, cp);
    cordic(ya, sy, cy);
    a_spsy  = rnd15(sp * sy);
    a_nspcy = rnd15(-(sp * cy));
    a_ncpsy = rnd15(-(cp * sy));
    a_cpcy  = rnd15(cp * cy);
    ox = longint'($signed(sh_ox));
    oy = longint'($signed(sh_oy));
    oz = longint'($signed(sh_oz));
    px = longint'(p.point_x) - ox;
    py = longint'(p.point_y) - oy;
    pz = longint'(p.point_z) - oz;
    rx = rnd15(cy * px + a_spsy * py + a_ncpsy * pz);
    ry = rnd15(cp * py + sp * pz);
    rz = rnd15(sy * px + a_nspcy * py + a_cpcy * pz);
    d = longint'($signed(sh_depth));
    if (d == 0) d = 1;
    s = (longint'(10000) << (2 * FRAC)) / d;
    den = s + rz;
    if (den == 0) begin
      ovf = 1'b1;
    end else begin
      fx = clamp24(rx - (rx * rz) / den + ox, ovf);
      fy = clamp24(ry - (ry * rz) / den + oy, ovf);
    end
    r.proj_x = fx[23:0];
    r.proj_y = fy[23:0];
    r.back_facing = ((pa < -11520) || (pa > 11520)) != ((ya < -11520) || (ya > 11520));
    r.overflow = ovf;
    return r;
  endfunction

  // Point driver: hold each request until taken, idle in random bursts.
  int in_gap = 0;
  always @(posedge clk) begin
    logic nxt_valid;
    in_t  nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        proj_q.push_back(project_point(in_data));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0 && !calm) begin
          in_gap--;
        end else if (point_q.size() > 0) begin
          nxt_data = point_q.pop_front();
          nxt_valid = 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 13);
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // Register write driver; writes go out only while the pipeline is empty.
  always @(posedge clk) begin
    logic       nxt_valid;
    reg_write_t w;
    nxt_valid = cfg_valid;
    w.idx = cfg_index;
    w.val = cfg_data;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PITCH:    sh_pitch = cfg_data[15:0];
          CFG_YAW:      sh_yaw = cfg_data[15:0];
          CFG_DEPTH:    sh_depth = cfg_data;
          CFG_ORIGIN_X: sh_ox = cfg_data;
          CFG_ORIGIN_Y: sh_oy = cfg_data;
          CFG_ORIGIN_Z: sh_oz = cfg_data;
          default: ;
        endcase
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && write_q.size() > 0) begin
        w = write_q.pop_front();
        nxt_valid = 1'b1;
      end
    end
    cfg_valid <= nxt_valid;
    cfg_index <= w.idx;
    cfg_data <= w.val;
  end

  // Result monitor: stall in random bursts, check against the oldest prediction.
  int out_stall = 0;
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (proj_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        want = proj_q.pop_front();
        if (out_data.proj_x !== want.proj_x)
          begin errors++; $display("%0t: proj_x expected %h actual %h", $time,
                                   want.proj_x, out_data.proj_x); end
        if (out_data.proj_y !== want.proj_y)
          begin errors++; $display("%0t: proj_y expected %h actual %h", $time,
                                   want.proj_y, out_data.proj_y); end
        if (out_data.back_facing !== want.back_facing)
          begin errors++; $display("%0t: back_facing expected %b actual %b", $time,
                                   want.back_facing, out_data.back_facing); end
        if (out_data.overflow !== want.overflow)
          begin errors++; $display("%0t: overflow expected %b actual %b", $time,
                                   want.overflow, out_data.overflow); end
      end
    end
    if (rst || calm) begin
      out_ready <= !rst;
      out_stall = 0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [23:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 131072)) - 65536);
      default: return 24'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  task automatic add_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    in_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    point_q.push_back(p);
  endtask

  task automatic add_write(logic [2:0] idx, logic [23:0] val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    write_q.push_back(w);
  endtask

  // Wait for all writes to land.
  task automatic settle_writes();
    while (write_q.size() > 0 || cfg_valid) @(posedge clk);
  endtask

  // Wait for the pipeline to drain, then give it time to go fully idle.
  task automatic drain();
    while (point_q.size() > 0 || in_valid || proj_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic full_config(logic [15:0] p, logic [15:0] yw, logic [23:0] d,
                             logic [23:0] x, logic [23:0] y, logic [23:0] z);
    add_write(CFG_PITCH, {8'($urandom), p});
    add_write(CFG_YAW, {8'($urandom), yw});
    add_write(CFG_DEPTH, d);
    add_write(CFG_ORIGIN_X, x);
    add_write(CFG_ORIGIN_Y, y);
    add_write(CFG_ORIGIN_Z, z);
    settle_writes();
  endtask

  task automatic directed_points();
    add_point(24'd0, 24'd0, 24'd0);
    add_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
    add_point(24'h800000, 24'h800000, 24'h800000);
    add_point(24'h7fffff, 24'h800000, 24'd0);
    add_point(24'd256, -24'sd256, 24'd512);
    // Zero divisor with the reset view: rz lands on minus the strength.
    add_point(24'd0, 24'd0, -24'sd256000);
    add_point(24'd1000, 24'd2000, -24'sd255999);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values first.
    directed_points();
    drain();

    // Half-turn angles, zero depth, lowest origins.
    full_config(16'sd23040, -16'sd23040, 24'd0, 24'h800000, 24'h800000, 24'h800000);
    directed_points();
    drain();

    // Pitch just past a quarter turn, yaw on one, negative depth, highest origins, dead indexes.
    full_config(16'sd11521, 16'sd11520, -24'sd1, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    add_write(3'd6, 24'hffffff);
    add_write(3'd7, 24'h123456);
    settle_writes();
    directed_points();
    drain();

    // Angles beyond a half turn wrap; extreme depths.
    full_config(16'sh7fff, 16'sh8000, 24'h7fffff, 24'd0, 24'd0, 24'd0);
    directed_points();
    drain();
    full_config(-16'sd11521, 16'sd0, 24'h800000, 24'd100, -24'sd100, 24'd0);
    directed_points();
    drain();

    // Random phases, each with its own register set.
    for (int ph = 0; ph < 8; ph++) begin
      full_config(16'($urandom),
                  16'($urandom),
                  ($urandom_range(0, 2) == 0) ? 24'($urandom)
                                              : 24'($urandom_range(1, 20000)),
                  ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'd0,
                  ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'd0,
                  ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'd0);
      if (ph == 7) calm = 1'b1;
      for (int k = 0; k < 250; k++) add_point(rnd_coord(), rnd_coord(), rnd_coord());
      drain();
    end

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
